[hw/rtl/pca_pkg.sv]
package pca_pkg;

  localparam int TIMEOUT_CHECKS = 6000;
  localparam int CNT_W          = 13;
  localparam int TMR_W          = 8;
  localparam int PH_W           = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int IN_DATA_W      = 16;
  localparam int OUT_DATA_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAF_WAIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUPLEX = 2'd3;

  localparam logic [7:0] SLOT_TIME_RST   = 8'd10;
  localparam logic [7:0] PERSISTENCE_RST = 8'd63;
  localparam logic [7:0] DEAF_WAIT_RST   = 8'd0;

  typedef struct packed {
    logic [7:0] slot_time;
    logic [7:0] persistence;
    logic [7:0] deaf_wait;
    logic       full_duplex;
  } pca_cfg_t;

  typedef struct packed {
    logic [7:0] random_byte;
    logic       device_free;
    logic       high_priority_waiting;
    logic       carrier_detect;
    logic       request;
  } pca_item_t;

  typedef struct packed {
    logic [PH_W-1:0] phase;
    logic            timed_out;
    logic            grant;
  } pca_res_t;

endpackage

[hw/rtl/pca_cfg.sv]
module pca_cfg import pca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output pca_cfg_t              cfg
);

  pca_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_time   <= SLOT_TIME_RST;
      cfg_r.persistence <= PERSISTENCE_RST;
      cfg_r.deaf_wait   <= DEAF_WAIT_RST;
      cfg_r.full_duplex <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SLOT_TIME:   cfg_r.slot_time   <= cfg_wdata;
        CFG_PERSISTENCE: cfg_r.persistence <= cfg_wdata;
        CFG_DEAF_WAIT:   cfg_r.deaf_wait   <= cfg_wdata;
        CFG_FULL_DUPLEX: cfg_r.full_duplex <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/pca_core.sv]
module pca_core import pca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  pca_item_t item,
  input  pca_cfg_t  cfg,
  output pca_res_t  res
);

  typedef enum logic [PH_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_CARRIER = 3'd1,
    PH_DEAF    = 3'd2,
    PH_SLOT    = 3'd3,
    PH_DEVICE  = 3'd4
  } phase_t;

  phase_t             ph_r, ph_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TMR_W-1:0]   tmr_r, tmr_nxt;
  logic               grant, tout;
  logic [TMR_W-1:0]   slot_load;
  logic               expired;

  assign slot_load = (cfg.slot_time == '0) ? TMR_W'(1) : cfg.slot_time;
  assign expired   = (cnt_r >= CNT_W'(TIMEOUT_CHECKS));

  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    tmr_nxt = tmr_r;
    grant   = 1'b0;
    tout    = 1'b0;
    case (ph_r)
      PH_IDLE: begin
        if (item.request) begin
          cnt_nxt = '0;
          tmr_nxt = '0;
          if (cfg.full_duplex) begin
            if (item.device_free) begin
              grant = 1'b1;
            end else begin
              ph_nxt = PH_DEVICE;
            end
          end else if (item.carrier_detect) begin
            ph_nxt = PH_CARRIER;
          end else if (cfg.deaf_wait != '0) begin
            ph_nxt  = PH_DEAF;
            tmr_nxt = cfg.deaf_wait;
          end else if (item.high_priority_waiting) begin
            if (item.device_free) begin
              grant = 1'b1;
            end else begin
              ph_nxt = PH_DEVICE;
            end
          end else begin
            ph_nxt  = PH_SLOT;
            tmr_nxt = slot_load;
          end
        end
      end
      PH_CARRIER: begin
        if (expired) begin
          tout   = 1'b1;
          ph_nxt = PH_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (item.carrier_detect) begin
            ph_nxt = PH_CARRIER;
          end else if (cfg.deaf_wait != '0) begin
            ph_nxt  = PH_DEAF;
            tmr_nxt = cfg.deaf_wait;
          end else if (item.high_priority_waiting) begin
            if (item.device_free) begin
              grant  = 1'b1;
              ph_nxt = PH_IDLE;
            end else begin
              ph_nxt = PH_DEVICE;
            end
          end else begin
            ph_nxt  = PH_SLOT;
            tmr_nxt = slot_load;
          end
        end
      end
      PH_DEAF, PH_SLOT: begin
        if (tmr_r > TMR_W'(1)) begin
          tmr_nxt = tmr_r - TMR_W'(1);
        end else begin
          tmr_nxt = '0;
          if (item.carrier_detect) begin
            ph_nxt = PH_CARRIER;
          end else if (item.high_priority_waiting ||
                       (ph_r == PH_SLOT && item.random_byte <= cfg.persistence)) begin
            if (item.device_free) begin
              grant  = 1'b1;
              ph_nxt = PH_IDLE;
            end else begin
              ph_nxt = PH_DEVICE;
            end
          end else begin
            ph_nxt  = PH_SLOT;
            tmr_nxt = slot_load;
          end
        end
      end
      PH_DEVICE: begin
        if (expired) begin
          tout   = 1'b1;
          ph_nxt = PH_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (item.device_free) begin
            grant  = 1'b1;
            ph_nxt = PH_IDLE;
          end
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      cnt_r <= '0;
      tmr_r <= '0;
    end else if (fire) begin
      ph_r  <= ph_nxt;
      cnt_r <= cnt_nxt;
      tmr_r <= tmr_nxt;
    end
  end

  assign res.grant     = grant;
  assign res.timed_out = tout;
  assign res.phase     = ph_nxt;

  a_grant_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (grant || tout)) |=> (ph_r == PH_IDLE))
    else $error("grant or timeout not followed by idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TIMEOUT_CHECKS))
    else $error("check count past timeout limit");

  a_tmr_live: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_DEAF || ph_r == PH_SLOT) |-> (tmr_r != '0))
    else $error("timer zero in a timed wait");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(ph_r) && $stable(cnt_r) && $stable(tmr_r)))
    else $error("state moved without an item");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(grant && tout))
    else $error("grant and timeout together");

endmodule

[hw/rtl/p_persistent_channel_access.sv]
// p-persistent channel access controller for one radio channel.
// in channel: one item per 10 ms tick carrying the request, carrier detect,
//   high priority flag, device free flag and a random byte.
// out channel: one result per tick with grant, timed_out and the phase
//   after that tick (0 idle, 1 carrier wait, 2 deaf wait, 3 slot wait,
//   4 device wait).
// cfg port: write-only registers slot_time, persistence, deaf_wait,
//   full_duplex at indexes 0..3; write only while no item is in flight.
// path: an accepted item waits in the input register, and its result is
//   captured in the result register, from which it leaves.
// throughput: one item per cycle if out_tready is high; the tick update is
//   one pass of logic between the input register and the result register.
// reset: phase idle, counters cleared, registers at their defaults,
//   both pipeline stages empty.
// stall: while out_tready is low and a result waits, the result register
//   holds; an empty input register takes one item, then in_tready drops.
module p_persistent_channel_access import pca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // request, carrier_detect, high_priority_waiting, device_free,
  // random_byte[7:0], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // grant, timed_out, phase[2:0], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  pca_cfg_t  cfg;
  pca_item_t item_r;
  pca_res_t  res, res_r;
  logic      v1_r, v2_r;
  logic      adv2, fire;

  pca_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign adv2      = !v2_r || out_tready;
  assign fire      = v1_r && adv2;
  assign in_tready = !v1_r || adv2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_tready) begin
        v1_r <= in_tvalid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_tdata[$bits(pca_item_t)-1:0];
    end
    if (fire) begin
      res_r <= res;
    end
  end

  pca_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_tvalid = v2_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(pca_res_t)){1'b0}}, res_r};

endmodule
